// ----- src/smspdu_pkg.sv -----
`timescale 1ns / 1ps

package smspdu_pkg;

  // Limits on the configured lengths; beyond them the message is rejected.
  localparam logic [3:0] MAX_DIGITS = 4'd11;
  localparam logic [6:0] MAX_CHARS  = 7'd67;

  // Number of digit nibbles the phone register can hold.
  localparam int unsigned PHONE_NIBBLES = 11;

  // Default depth of the command queue between front and back.
  localparam int unsigned CMD_QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [2:0] REG_PHONE_DIGITS   = 3'd0;
  localparam logic [2:0] REG_PHONE_LENGTH   = 3'd1;
  localparam logic [2:0] REG_MESSAGE_LENGTH = 3'd2;
  localparam logic [2:0] REG_CONCAT_REF     = 3'd3;
  localparam logic [2:0] REG_PARTS_TOTAL    = 3'd4;
  localparam logic [2:0] REG_PART_INDEX     = 3'd5;

  localparam logic [6:0] CHAR_ZERO = 7'h30;

  // Last nibble index of each fixed-length section.
  localparam logic [4:0] FIXED_LAST = 5'd9;
  localparam logic [4:0] TAIL_LAST  = 5'd5;
  localparam logic [4:0] UDH_LAST   = 5'd11;
  localparam logic [4:0] BODY_LAST  = 5'd3;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MSG_LONG   = 2'd1,
    ST_PHONE_LONG = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_BODY = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FIXED  = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TAIL   = 3'd3,
    PH_UDH    = 3'd4,
    PH_BODY   = 3'd5,
    PH_ERR    = 3'd6
  } phase_e;

  typedef struct packed {
    logic [43:0] phone_digits;
    logic [3:0]  phone_length;
    logic [6:0]  message_length;
    logic [7:0]  concat_reference;
    logic [7:0]  parts_total;
    logic [7:0]  part_index;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_code;
    logic       last;
    status_e    status;
  } cmd_t;

  function automatic logic [6:0] hex_of(input logic [3:0] nib);
    hex_of = (nib < 4'd10) ? (7'h30 + {3'b000, nib}) : (7'h37 + {3'b000, nib});
  endfunction

  // A zero message length counts as one character.
  function automatic logic [6:0] eff_len(input logic [6:0] len);
    eff_len = (len == 7'd0) ? 7'd1 : len;
  endfunction

  // cp1251 to UCS2 without its top nibble, which is always zero.
  function automatic logic [11:0] ucs2_of(input logic [7:0] c);
    if (c == 8'hA8) begin
      ucs2_of = 12'h401;
    end else if (c == 8'hB8) begin
      ucs2_of = 12'h451;
    end else if (c >= 8'hC0) begin
      ucs2_of = {4'h0, c} + 12'h350;
    end else begin
      ucs2_of = {4'h0, c};
    end
  endfunction

endpackage

// ----- src/smspdu_front.sv -----
`timescale 1ns / 1ps

// Accepts message bytes, tracks the position in the message and turns each
// byte into a command for the back end.
module smspdu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  smspdu_pkg::cfg_t   cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_char_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output smspdu_pkg::cmd_t   q_cmd_o
);

  logic [6:0]          chars_seen_q, chars_seen_d;
  logic                error_latched_q, error_latched_d;
  logic [6:0]          len;
  logic                first, is_last, accept;
  smspdu_pkg::status_e status;

  assign len     = smspdu_pkg::eff_len(cfg_i.message_length);
  assign first   = (chars_seen_q == 7'd0);
  assign is_last = ({1'b0, chars_seen_q} + 8'd1) >= {1'b0, len};

  always_comb begin
    if (cfg_i.phone_length > smspdu_pkg::MAX_DIGITS) begin
      status = smspdu_pkg::ST_PHONE_LONG;
    end else if (len > smspdu_pkg::MAX_CHARS) begin
      status = smspdu_pkg::ST_MSG_LONG;
    end else begin
      status = smspdu_pkg::ST_OK;
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Bytes of a rejected message are swallowed without a command.
  assign q_push_o = accept && (first || !error_latched_q);

  always_comb begin
    q_cmd_o.char_code = in_char_i;
    q_cmd_o.last      = is_last;
    q_cmd_o.status    = smspdu_pkg::ST_OK;
    if (!first) begin
      q_cmd_o.kind = smspdu_pkg::KIND_BODY;
    end else if (status != smspdu_pkg::ST_OK) begin
      q_cmd_o.kind   = smspdu_pkg::KIND_ERR;
      q_cmd_o.status = status;
    end else begin
      q_cmd_o.kind = smspdu_pkg::KIND_HDR;
    end
  end

  always_comb begin
    chars_seen_d    = chars_seen_q;
    error_latched_d = error_latched_q;
    if (accept) begin
      if (is_last) begin
        chars_seen_d    = 7'd0;
        error_latched_d = 1'b0;
      end else begin
        chars_seen_d = chars_seen_q + 7'd1;
        if (first) begin
          error_latched_d = (status != smspdu_pkg::ST_OK);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_seen_q    <= 7'd0;
      error_latched_q <= 1'b0;
    end else begin
      chars_seen_q    <= chars_seen_d;
      error_latched_q <= error_latched_d;
    end
  end

endmodule

// ----- src/smspdu_queue.sv -----
`timescale 1ns / 1ps

// Small command FIFO between the front and the back end.
module smspdu_queue #(
  parameter int unsigned DEPTH = smspdu_pkg::CMD_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  smspdu_pkg::cmd_t push_cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output smspdu_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  smspdu_pkg::cmd_t  entries_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o    = (count_q == CNT_FULL);
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = entries_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- src/smspdu_back.sv -----
`timescale 1ns / 1ps

// Walks the PDU one hex character per cycle, while the output is not stalled,
// for each command and drives the registered output stage.
module smspdu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  smspdu_pkg::cfg_t cfg_i,
  input  logic             q_valid_i,
  input  smspdu_pkg::cmd_t q_cmd_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [6:0]       out_char_o,
  output logic             out_last_o,
  output logic [1:0]       out_status_o
);

  smspdu_pkg::phase_e phase_q, phase_d;
  logic [4:0]         cnt_q, cnt_d;
  smspdu_pkg::cmd_t   cur_q;

  logic               out_valid_q;
  logic [6:0]         out_char_q;
  logic               out_last_q;
  logic [1:0]         out_status_q;

  logic               emit, done;
  logic [3:0]         nib;
  logic [6:0]         char_c;
  logic               last_c;
  logic [1:0]         status_c;

  logic               concat;
  logic [4:0]         n_digit_chars;
  logic [7:0]         udl;
  logic [11:0]        ucs2;
  logic [3:0]         digit_idx;
  logic [3:0]         digit_nib;
  logic [43:0]        digit_shift;

  assign concat        = (cfg_i.parts_total != 8'd0);
  assign n_digit_chars = ({1'b0, cfg_i.phone_length} + 5'd1) & 5'b11110;
  assign udl           = {smspdu_pkg::eff_len(cfg_i.message_length), 1'b0}
                         + (concat ? 8'd6 : 8'd0);
  assign ucs2          = smspdu_pkg::ucs2_of(cur_q.char_code);

  // Digits go out swapped in pairs; positions past the count read as F.
  assign digit_idx   = cnt_q[3:0] ^ 4'd1;
  assign digit_shift = cfg_i.phone_digits >> {digit_idx, 2'b00};
  always_comb begin
    if (digit_idx >= cfg_i.phone_length) begin
      digit_nib = 4'hF;
    end else if (digit_idx >= 4'(smspdu_pkg::PHONE_NIBBLES)) begin
      digit_nib = 4'h0;
    end else begin
      digit_nib = digit_shift[3:0];
    end
  end

  assign emit = (phase_q != smspdu_pkg::PH_IDLE) && (!out_valid_q || out_ready_i);

  // Output decode for the current phase and position.
  always_comb begin
    nib      = 4'h0;
    last_c   = 1'b0;
    status_c = smspdu_pkg::ST_OK;
    done     = 1'b0;
    unique case (phase_q)
      smspdu_pkg::PH_FIXED: begin
        case (cnt_q)
          5'd2:    nib = concat ? 4'h4 : 4'h0;
          5'd3:    nib = 4'h1;
          5'd7:    nib = cfg_i.phone_length;
          5'd8:    nib = 4'h9;
          5'd9:    nib = 4'h1;
          default: nib = 4'h0;
        endcase
      end
      smspdu_pkg::PH_DIGITS: nib = digit_nib;
      smspdu_pkg::PH_TAIL: begin
        case (cnt_q)
          5'd3:    nib = 4'h8;
          5'd4:    nib = udl[7:4];
          5'd5:    nib = udl[3:0];
          default: nib = 4'h0;
        endcase
      end
      smspdu_pkg::PH_UDH: begin
        case (cnt_q)
          5'd1:    nib = 4'h5;
          5'd5:    nib = 4'h3;
          5'd6:    nib = cfg_i.concat_reference[7:4];
          5'd7:    nib = cfg_i.concat_reference[3:0];
          5'd8:    nib = cfg_i.parts_total[7:4];
          5'd9:    nib = cfg_i.parts_total[3:0];
          5'd10:   nib = cfg_i.part_index[7:4];
          5'd11:   nib = cfg_i.part_index[3:0];
          default: nib = 4'h0;
        endcase
      end
      smspdu_pkg::PH_BODY: begin
        case (cnt_q)
          5'd1:    nib = ucs2[11:8];
          5'd2:    nib = ucs2[7:4];
          5'd3:    nib = ucs2[3:0];
          default: nib = 4'h0;
        endcase
        done   = (cnt_q == smspdu_pkg::BODY_LAST);
        last_c = done && cur_q.last;
      end
      smspdu_pkg::PH_ERR: begin
        last_c   = 1'b1;
        status_c = cur_q.status;
        done     = 1'b1;
      end
      default: ;
    endcase
    char_c = (phase_q == smspdu_pkg::PH_ERR) ? smspdu_pkg::CHAR_ZERO : smspdu_pkg::hex_of(nib);
  end

  assign q_pop_o = q_valid_i && ((phase_q == smspdu_pkg::PH_IDLE) || (emit && done));

  // Phase sequencing.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (emit) begin
      cnt_d = cnt_q + 5'd1;
      unique case (phase_q)
        smspdu_pkg::PH_FIXED: begin
          if (cnt_q == smspdu_pkg::FIXED_LAST) begin
            cnt_d   = 5'd0;
            phase_d = (n_digit_chars == 5'd0) ? smspdu_pkg::PH_TAIL : smspdu_pkg::PH_DIGITS;
          end
        end
        smspdu_pkg::PH_DIGITS: begin
          if (cnt_q == n_digit_chars - 5'd1) begin
            cnt_d   = 5'd0;
            phase_d = smspdu_pkg::PH_TAIL;
          end
        end
        smspdu_pkg::PH_TAIL: begin
          if (cnt_q == smspdu_pkg::TAIL_LAST) begin
            cnt_d   = 5'd0;
            phase_d = concat ? smspdu_pkg::PH_UDH : smspdu_pkg::PH_BODY;
          end
        end
        smspdu_pkg::PH_UDH: begin
          if (cnt_q == smspdu_pkg::UDH_LAST) begin
            cnt_d   = 5'd0;
            phase_d = smspdu_pkg::PH_BODY;
          end
        end
        smspdu_pkg::PH_BODY,
        smspdu_pkg::PH_ERR: begin
          if (done) begin
            cnt_d   = 5'd0;
            phase_d = smspdu_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase
    end
    if (q_pop_o) begin
      cnt_d = 5'd0;
      unique case (q_cmd_i.kind)
        smspdu_pkg::KIND_HDR:  phase_d = smspdu_pkg::PH_FIXED;
        smspdu_pkg::KIND_BODY: phase_d = smspdu_pkg::PH_BODY;
        smspdu_pkg::KIND_ERR:  phase_d = smspdu_pkg::PH_ERR;
        default:               phase_d = smspdu_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= smspdu_pkg::PH_IDLE;
      cnt_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_cmd_i;
    end
    if (emit) begin
      out_char_q   <= char_c;
      out_last_q   <= last_c;
      out_status_q <= status_c;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

endmodule

// ----- src/sms_submit_pdu_hex_encoder_unit.sv -----
`timescale 1ns / 1ps

// SMS-SUBMIT PDU encoder with UCS2 payload and uppercase hex ASCII output.
// The slave stream takes one cp1251 message byte per word. The master stream
// gives one hex character per word; tlast marks the final character of the
// PDU or an error word, and tuser carries the status (0 ok, 1 message too
// long, 2 phone number too long). Configuration is written through a plain
// write port (enable, index, data); the user must write it only while no
// message is in flight; the block does not enforce this. The first byte of a
// message produces the header (16 to 40 characters, depending on the digit
// count and whether the part is concatenated) followed by that byte's four
// UCS2 characters; each further byte produces four characters. A rejected
// message yields one error word; its remaining bytes are taken and dropped.
// Throughput is one character per cycle while the output is not stalled,
// set by the back-end sequencer that emits one nibble a cycle. Each byte goes
// through the queue, the phase register and the output register to the output.
// A command queue between the front end and the sequencer lets input bytes
// be taken while the output is stalled; when it fills, s_axis_tready falls.
// A held output word stays stable until m_axis_tready is seen high.
// Reset clears the message position, the queue and the output stage, and
// loads the configuration defaults (11 digits, length 1, reference 1).
module sms_submit_pdu_hex_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = smspdu_pkg::CMD_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] hex_char, [7] zero
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [43:0] cfg_wdata_i
);

  smspdu_pkg::cfg_t cfg_q;
  smspdu_pkg::cmd_t push_cmd, pop_cmd;
  logic             q_push, q_full, q_pop, q_valid;
  logic [6:0]       out_char;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phone_digits     <= 44'd0;
      cfg_q.phone_length     <= 4'd11;
      cfg_q.message_length   <= 7'd1;
      cfg_q.concat_reference <= 8'd1;
      cfg_q.parts_total      <= 8'd0;
      cfg_q.part_index       <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        smspdu_pkg::REG_PHONE_DIGITS:   cfg_q.phone_digits     <= cfg_wdata_i;
        smspdu_pkg::REG_PHONE_LENGTH:   cfg_q.phone_length     <= cfg_wdata_i[3:0];
        smspdu_pkg::REG_MESSAGE_LENGTH: cfg_q.message_length   <= cfg_wdata_i[6:0];
        smspdu_pkg::REG_CONCAT_REF:     cfg_q.concat_reference <= cfg_wdata_i[7:0];
        smspdu_pkg::REG_PARTS_TOTAL:    cfg_q.parts_total      <= cfg_wdata_i[7:0];
        smspdu_pkg::REG_PART_INDEX:     cfg_q.part_index       <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // The front end classifies each byte as header, body, error or drop.
  smspdu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  smspdu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  // The back end expands each command into hex characters.
  smspdu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_cmd_i      (pop_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (out_char),
    .out_last_o   (m_axis_tlast),
    .out_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, out_char};

  // The front end never pushes into a full queue.
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // An error word is always a lone '0' that closes the message.
  a_error_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != smspdu_pkg::ST_OK) |->
      (m_axis_tlast && m_axis_tdata[6:0] == smspdu_pkg::CHAR_ZERO))
    else $error("error word malformed");

  // Every character is an uppercase hex digit.
  a_hex_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tdata[6:0] >= 7'h30 && m_axis_tdata[6:0] <= 7'h39) ||
       (m_axis_tdata[6:0] >= 7'h41 && m_axis_tdata[6:0] <= 7'h46)))
    else $error("output is not a hex digit");

  // Popping requires a queued command.
  a_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// ----- verif/sms_submit_pdu_hex_encoder_unit_test.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the SMS-SUBMIT PDU hex encoder.
module sms_submit_pdu_hex_encoder_unit_test;

  import smspdu_pkg::*;

  // A bad run can stall on a missing word, so the counter ends it. The slowest
  // correct run has roughly 500 bytes, each of up to 44 words, each word
  // waiting on the sink, plus the long hold-off and the settle gaps between
  // phases; the limit lies above all of that.
  localparam int LIMIT_CYCLES   = 600000;
  localparam int RANDOM_ITEMS   = 470;
  // Dropped bytes never reach the command queue; still, after the last word has
  // left, the bench waits this long before a register write.
  localparam int SETTLE_CYCLES  = 32;
  localparam int HOLD_CYCLES    = 500;
  localparam int IDLE_PERCENT   = 29;
  localparam int MAX_PRINTED    = 40;
  localparam int N_DIRECTED     = 35;

  // One word on the master stream.
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
    status_e    st;
  } pdu_word_t;

  typedef enum logic {
    ROW_CFG  = 1'b0,
    ROW_BYTE = 1'b1
  } row_kind_e;

  // A directed row either writes a register or sends one byte. When typed is
  // set, the final word the byte causes is taken from the row, not predicted.
  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [43:0] value;
    logic        typed;
    pdu_word_t   want;
  } stim_row_t;

  localparam pdu_word_t NO_WORD = '{CHAR_ZERO, 1'b0, ST_OK};

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  // Every input of the block starts at a known value.
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_index_i   = REG_PHONE_DIGITS;
  logic [43:0] cfg_wdata_i   = '0;

  sms_submit_pdu_hex_encoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Shadow copy of the configuration and the message position.
  logic [43:0] dial_digits;
  logic [3:0]  dial_count;
  logic [6:0]  msg_len_set;
  logic [7:0]  concat_ref_set;
  logic [7:0]  parts_set;
  logic [7:0]  part_no_set;
  logic [6:0]  bytes_in_msg;
  bit          dropping_msg;

  pdu_word_t   pending_pdu_words [$];

  int  mismatches      = 0;
  int  words_checked   = 0;
  int  bytes_producing = 0;
  int  cycle_count     = 0;
  bit  no_idle         = 1'b0;
  bit  rx_hold_req     = 1'b0;
  bit  cfg_open        = 1'b0;

  // Directed rows: extremes of the byte, the cp1251 special letters, both
  // errors with the dropped remainder of the message, zero message length,
  // zero and odd phone lengths, and a concatenated part with extreme header
  // fields. Register writes in the middle of a dropped message shorten it.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_BYTE, '0, 44'h00, 1'b1, '{CHAR_ZERO, 1'b1, ST_OK}},
    '{ROW_BYTE, '0, 44'hFF, 1'b1, '{7'h46, 1'b1, ST_OK}},
    '{ROW_CFG, REG_PHONE_LENGTH, 44'd12, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, 44'h41, 1'b1, '{CHAR_ZERO, 1'b1, ST_PHONE_LONG}},
    '{ROW_CFG, REG_PHONE_LENGTH, 44'd0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_MESSAGE_LENGTH, 44'd0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, 44'hA8, 1'b0, NO_WORD},
    '{ROW_CFG, REG_PHONE_DIGITS, 44'hFEDCBA98765, 1'b0, NO_WORD},
    '{ROW_CFG, REG_PHONE_LENGTH, 44'd11, 1'b0, NO_WORD},
    '{ROW_CFG, REG_MESSAGE_LENGTH, 44'd3, 1'b0, NO_WORD},
    '{ROW_CFG, REG_PARTS_TOTAL, 44'd255, 1'b0, NO_WORD},
    '{ROW_CFG, REG_PART_INDEX, 44'd255, 1'b0, NO_WORD},
    '{ROW_CFG, REG_CONCAT_REF, 44'd0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, 44'hB8, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, 44'hC0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, 44'hBF, 1'b0, NO_WORD},
    '{ROW_CFG, REG_MESSAGE_LENGTH, 44'd68, 1'b0, NO_WORD},
    '{ROW_CFG, REG_PARTS_TOTAL, 44'd0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, 44'h80, 1'b1, '{CHAR_ZERO, 1'b1, ST_MSG_LONG}},
    '{ROW_BYTE, '0, 44'h7F, 1'b0, NO_WORD},
    '{ROW_CFG, REG_MESSAGE_LENGTH, 44'd3, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, 44'h55, 1'b0, NO_WORD},
    '{ROW_CFG, REG_PHONE_LENGTH, 44'd15, 1'b0, NO_WORD},
    '{ROW_CFG, REG_MESSAGE_LENGTH, 44'd127, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, 44'h3F, 1'b1, '{CHAR_ZERO, 1'b1, ST_PHONE_LONG}},
    '{ROW_CFG, REG_MESSAGE_LENGTH, 44'd2, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, 44'h20, 1'b0, NO_WORD},
    '{ROW_CFG, REG_PHONE_DIGITS, 44'hFFFFFFFFFFF, 1'b0, NO_WORD},
    '{ROW_CFG, REG_PHONE_LENGTH, 44'd1, 1'b0, NO_WORD},
    '{ROW_CFG, REG_PARTS_TOTAL, 44'd1, 1'b0, NO_WORD},
    '{ROW_CFG, REG_PART_INDEX, 44'd1, 1'b0, NO_WORD},
    '{ROW_CFG, REG_CONCAT_REF, 44'd255, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, 44'h01, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, 44'hE0, 1'b0, NO_WORD},
    '{ROW_CFG, REG_PHONE_DIGITS, 44'd0, 1'b0, NO_WORD}
  };

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic [6:0] ascii_hex(input logic [3:0] nib);
    return (nib < 4'd10) ? 7'h30 + 7'(nib) : 7'h41 + 7'(nib - 4'd10);
  endfunction

  function automatic logic [15:0] cp1251_to_ucs2(input logic [7:0] c);
    if (c == 8'hA8) return 16'h0401;
    if (c == 8'hB8) return 16'h0451;
    if (c >= 8'hC0) return 16'(c) + 16'h0350;
    return 16'(c);
  endfunction

  // Digits past the configured count are the F padding.
  function automatic logic [3:0] phone_nibble(input int i);
    if (i >= int'(dial_count)) return 4'hF;
    if (i >= PHONE_NIBBLES) return 4'h0;
    return dial_digits[4*i +: 4];
  endfunction

  function automatic void push_word(input logic [6:0] ch, input logic last, input status_e st);
    pdu_word_t w;
    w.ch   = ch;
    w.last = last;
    w.st   = st;
    pending_pdu_words.push_back(w);
  endfunction

  function automatic void push_octet(input logic [7:0] b);
    push_word(ascii_hex(b[7:4]), 1'b0, ST_OK);
    push_word(ascii_hex(b[3:0]), 1'b0, ST_OK);
  endfunction

  function automatic void load_reset_settings();
    dial_digits    = '0;
    dial_count     = 4'd11;
    msg_len_set    = 7'd1;
    concat_ref_set = 8'd1;
    parts_set      = 8'd0;
    part_no_set    = 8'd0;
    bytes_in_msg   = '0;
    dropping_msg   = 1'b0;
  endfunction

  function automatic void store_setting(input logic [2:0] idx, input logic [43:0] val);
    case (idx)
      REG_PHONE_DIGITS:   dial_digits    = val;
      REG_PHONE_LENGTH:   dial_count     = val[3:0];
      REG_MESSAGE_LENGTH: msg_len_set    = val[6:0];
      REG_CONCAT_REF:     concat_ref_set = val[7:0];
      REG_PARTS_TOTAL:    parts_set      = val[7:0];
      REG_PART_INDEX:     part_no_set    = val[7:0];
      default: ;
    endcase
  endfunction

  // Appends the words that one accepted byte causes and returns their count.
  function automatic int pdu_words_for_byte(input logic [7:0] c);
    int        before_n;
    int        len;
    int        pairs;
    bit        ends;
    status_e   verdict;
    logic [15:0] ucs;
    logic [7:0]  udl;
    before_n = pending_pdu_words.size();
    len      = (msg_len_set == 7'd0) ? 1 : int'(msg_len_set);
    ends     = (int'(bytes_in_msg) + 1 >= len);

    if (bytes_in_msg == '0) begin
      // The first byte of a message carries the whole header, or the error.
      verdict = ST_OK;
      if (dial_count > MAX_DIGITS) verdict = ST_PHONE_LONG;
      else if (len > int'(MAX_CHARS)) verdict = ST_MSG_LONG;
      if (verdict != ST_OK) begin
        push_word(CHAR_ZERO, 1'b1, verdict);
        dropping_msg = 1'b1;
      end else begin
        push_octet(8'h00);
        push_octet((parts_set != 8'd0) ? 8'h41 : 8'h01);
        push_octet(8'h00);
        push_octet(8'(dial_count));
        push_octet(8'h91);
        pairs = (int'(dial_count) + 1) / 2;
        for (int p = 0; p < pairs; p++) begin
          push_word(ascii_hex(phone_nibble(2*p + 1)), 1'b0, ST_OK);
          push_word(ascii_hex(phone_nibble(2*p)), 1'b0, ST_OK);
        end
        push_octet(8'h00);
        push_octet(8'h08);
        udl = (parts_set != 8'd0) ? 8'(2*len + 6) : 8'(2*len);
        push_octet(udl);
        if (parts_set != 8'd0) begin
          push_octet(8'h05);
          push_octet(8'h00);
          push_octet(8'h03);
          push_octet(concat_ref_set);
          push_octet(parts_set);
          push_octet(part_no_set);
        end
      end
    end

    if (!dropping_msg) begin
      ucs = cp1251_to_ucs2(c);
      push_word(ascii_hex(ucs[15:12]), 1'b0, ST_OK);
      push_word(ascii_hex(ucs[11:8]), 1'b0, ST_OK);
      push_word(ascii_hex(ucs[7:4]), 1'b0, ST_OK);
      push_word(ascii_hex(ucs[3:0]), ends, ST_OK);
    end

    if (ends) begin
      bytes_in_msg = '0;
      dropping_msg = 1'b0;
    end else begin
      bytes_in_msg = bytes_in_msg + 7'd1;
    end
    return pending_pdu_words.size() - before_n;
  endfunction

  // ---------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------

  // Leaves tvalid high after the handshake so that back-to-back bytes do not
  // lower and raise it in the same step.
  task automatic send_byte(input logic [7:0] c, input bit typed, input pdu_word_t typed_word);
    int produced;
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    produced = pdu_words_for_byte(c);
    if (produced > 0) begin
      bytes_producing++;
      if (typed) pending_pdu_words[pending_pdu_words.size() - 1] = typed_word;
    end
  endtask

  // Write enable stays high across consecutive writes; it is lowered before the
  // next byte is sent or by the next settle.
  task automatic write_reg(input logic [2:0] idx, input logic [43:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    store_setting(idx, val);
    cfg_open = 1'b1;
  endtask

  // Brings the block to rest: no byte offered, every word out, and then the
  // settle wait.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_open = 1'b0;
    while (pending_pdu_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_char();
    logic [7:0] specials [8] = '{8'h00, 8'h7F, 8'h80, 8'hA8, 8'hB8, 8'hBF, 8'hC0, 8'hFF};
    if ($urandom_range(99) < 12) return specials[$urandom_range(7)];
    return 8'($urandom_range(255));
  endfunction

  // One random phase: a fresh setting, then a burst of messages. Most bursts
  // are whole messages; some are cut short so the next setting picks up a
  // message in the middle. Rejected settings get the error byte and up to three
  // dropped bytes.
  task automatic random_phase(input int phase);
    logic [63:0] digits;
    logic [3:0]  plen;
    logic [6:0]  mlen;
    logic [7:0]  parts;
    int          eff;
    int          nbytes;
    int          r;
    digits = {$urandom(), $urandom()};
    r = $urandom_range(99);
    plen = (r < 6) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
    r = $urandom_range(99);
    if (r < 5) mlen = 7'($urandom_range(127, 68));
    else if (r < 10) mlen = 7'd0;
    else if (r < 16) mlen = 7'($urandom_range(67, 60));
    else mlen = 7'($urandom_range(6, 1));
    parts = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255));

    // The long hold-off phase: many words per byte so the queue fills.
    if (phase == 1) begin
      plen  = 4'd11;
      mlen  = 7'd2;
      parts = 8'd3;
    end
    no_idle = (phase >= 4 && phase <= 8);

    settle();
    write_reg(REG_PHONE_DIGITS, digits[43:0]);
    write_reg(REG_PHONE_LENGTH, 44'(plen));
    write_reg(REG_MESSAGE_LENGTH, 44'(mlen));
    write_reg(REG_CONCAT_REF, 44'($urandom_range(255)));
    write_reg(REG_PARTS_TOTAL, 44'(parts));
    write_reg(REG_PART_INDEX, 44'($urandom_range(255)));
    cfg_we_i <= 1'b0;
    cfg_open = 1'b0;

    eff = (mlen == 7'd0) ? 1 : int'(mlen);
    if (plen > MAX_DIGITS || eff > int'(MAX_CHARS)) begin
      nbytes = 1 + $urandom_range(3);
    end else if (phase == 1) begin
      nbytes = 5 * eff;
    end else begin
      nbytes = (eff >= 60) ? eff : eff * $urandom_range(5, 2);
      if (nbytes > 1 && $urandom_range(99) < 15) nbytes -= $urandom_range(nbytes - 1, 1);
    end

    if (phase == 1) rx_hold_req = 1'b1;
    for (int i = 0; i < nbytes; i++) send_byte(random_char(), 1'b0, NO_WORD);
  endtask

  // ---------------------------------------------------------------------
  // Sink side
  // ---------------------------------------------------------------------

  // The sink idles at random. On request it holds tready low for a long
  // stretch, counted here, while the source keeps offering bytes.
  initial begin : result_sink
    int hold_left;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTED) begin
      $display("mismatch on %0s at word %0d: got %0h, expected %0h",
               what, words_checked, got, want);
    end
    mismatches++;
  endtask

  // Each accepted word is compared with the oldest expectation. A word that
  // appears at this edge was caused by a byte taken at an earlier edge, so
  // its expectation is already queued.
  always @(posedge clk_i) begin : word_check
    pdu_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pdu_words.size() == 0) begin
        report_mismatch("unexpected word", int'(m_axis_tdata), 0);
      end else begin
        want = pending_pdu_words.pop_front();
        if (m_axis_tdata !== {1'b0, want.ch})
          report_mismatch("hex_char", int'(m_axis_tdata), int'(want.ch));
        if (m_axis_tlast !== want.last)
          report_mismatch("last_of_message", int'(m_axis_tlast), int'(want.last));
        if (m_axis_tuser !== want.st)
          report_mismatch("status", int'(m_axis_tuser), int'(want.st));
      end
      words_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin : stimulus
    stim_row_t row;
    int        phase;
    load_reset_settings();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A register write only happens once the block is idle.
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        if (!cfg_open) settle();
        write_reg(row.reg_idx, row.value);
      end else begin
        if (cfg_open) begin
          cfg_we_i <= 1'b0;
          cfg_open = 1'b0;
        end
        send_byte(row.value[7:0], row.typed, row.want);
      end
    end

    // Random part, one setting per phase.
    phase = 0;
    while (bytes_producing < RANDOM_ITEMS) begin
      random_phase(phase);
      phase++;
    end

    no_idle = 1'b0;
    settle();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/smspdu_pkg.sv
src/smspdu_front.sv
src/smspdu_queue.sv
src/smspdu_back.sv
src/sms_submit_pdu_hex_encoder_unit.sv
verif/sms_submit_pdu_hex_encoder_unit_test.sv
